[hdl/gww_pkg.sv]
// shared types and constants of the greedy word wrap line writer
package gww_pkg;

  localparam int CHAR_BITS = 8;
  localparam int ROW_BITS  = 4;
  localparam int COL_BITS  = 6;
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 24;

  localparam logic [CHAR_BITS-1:0] CHAR_END     = 8'd0;
  localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'd32;
  localparam logic [CHAR_BITS-1:0] GLYPH_EOL    = 8'd0;

  // classified character as it sits in the queue
  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 is_end;
    logic                 is_nl;
    logic                 is_space;
  } gww_item_t;

endpackage

[hdl/gww_ram.sv]
// generic single write port ram with registered read
module gww_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/gww_front.sv]
// front end: accepts characters, classifies them and queues them
module gww_front
  import gww_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAR_BITS-1:0] in_char,
  output logic                 q_valid,
  output gww_item_t            q_item,
  input  logic                 q_pop
);

  gww_item_t  entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  gww_item_t  item;

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = entry_r[rd_ptr_r];

  always_comb begin
    item.ch       = in_char;
    item.is_end   = (in_char == CHAR_END);
    item.is_nl    = (in_char == CHAR_NEWLINE);
    item.is_space = (in_char == CHAR_SPACE);
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      if (push) begin
        entry_r[wr_ptr_r] <= item;
      end
    end
  end

endmodule

[hdl/gww_back.sv]
// back end: row and column tracking, wrap replay and the output register
module gww_back
  import gww_pkg::*;
#(
  parameter int ROW_WIDTH = 50,
  parameter int ROW_COUNT = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  gww_item_t            q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROW_BITS-1:0]  out_row,
  output logic [COL_BITS-1:0]  out_column,
  output logic [CHAR_BITS-1:0] out_glyph,
  output logic                 out_last
);

  localparam int CW  = $clog2(ROW_WIDTH + 1);
  localparam int AW  = $clog2(ROW_WIDTH);
  localparam int RBW = $clog2(ROW_COUNT + 1);
  localparam logic [CW-1:0]  COL_MAX  = CW'(ROW_WIDTH);
  localparam logic [RBW-1:0] ROW_MAX  = RBW'(ROW_COUNT);
  localparam logic [AW-1:0]  LAST_IDX = AW'(ROW_WIDTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_REPLAY, S_CHAR} state_t;

  state_t               state_r, state_nxt;
  logic [RBW-1:0]       row_r, row_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [AW-1:0]        sp_col_r, sp_col_nxt;
  logic                 sp_on_r, sp_on_nxt;
  gww_item_t            ch_r, ch_nxt;
  logic [AW-1:0]        src_r, src_nxt;
  logic [AW-1:0]        dst_r, dst_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ROW_BITS-1:0]  o_row_r, o_row_nxt;
  logic [COL_BITS-1:0]  o_col_r, o_col_nxt;
  logic [CHAR_BITS-1:0] o_glyph_r, o_glyph_nxt;
  logic                 o_last_r, o_last_nxt;

  logic                 out_free;
  logic                 char_go;
  gww_item_t            char_item;
  logic [RBW-1:0]       row_inc;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [CHAR_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [CHAR_BITS-1:0] ram_rdata;

  gww_ram #(
    .WIDTH(CHAR_BITS),
    .DEPTH(ROW_WIDTH)
  ) u_row_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_free   = !out_valid_r || out_ready;
  assign row_inc    = row_r + RBW'(1);
  assign out_valid  = out_valid_r;
  assign out_row    = o_row_r;
  assign out_column = o_col_r;
  assign out_glyph  = o_glyph_r;
  assign out_last   = o_last_r;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    sp_col_nxt    = sp_col_r;
    sp_on_nxt     = sp_on_r;
    ch_nxt        = ch_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    o_row_nxt     = o_row_r;
    o_col_nxt     = o_col_r;
    o_glyph_nxt   = o_glyph_r;
    o_last_nxt    = o_last_r;
    q_pop         = 1'b0;
    char_go       = 1'b0;
    char_item     = ch_r;
    ram_we        = 1'b0;
    ram_waddr     = col_r[AW-1:0];
    ram_wdata     = ch_r.ch;
    ram_raddr     = src_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_item.is_end) begin
            if (row_r < ROW_MAX) begin
              out_valid_nxt = 1'b1;
              o_row_nxt     = ROW_BITS'(row_r);
              o_col_nxt     = COL_BITS'(col_r);
              o_glyph_nxt   = GLYPH_EOL;
              o_last_nxt    = 1'b1;
            end
            row_nxt    = '0;
            col_nxt    = '0;
            sp_col_nxt = '0;
            sp_on_nxt  = 1'b0;
          end else if (row_r >= ROW_MAX) begin
            // past the final row: dropped
          end else if (col_r >= COL_MAX) begin
            // row full: terminate at last space or hard break
            out_valid_nxt = 1'b1;
            o_row_nxt     = ROW_BITS'(row_r);
            o_col_nxt     = sp_on_r ? COL_BITS'(sp_col_r) : COL_BITS'(col_r);
            o_glyph_nxt   = GLYPH_EOL;
            o_last_nxt    = (row_inc >= ROW_MAX);
            row_nxt       = row_inc;
            col_nxt       = '0;
            sp_on_nxt     = 1'b0;
            ch_nxt        = q_item;
            if (row_inc < ROW_MAX) begin
              if (sp_on_r && (sp_col_r != LAST_IDX)) begin
                ram_raddr = sp_col_r + AW'(1);
                src_nxt   = sp_col_r + AW'(1);
                dst_nxt   = '0;
                state_nxt = S_REPLAY;
              end else begin
                state_nxt = S_CHAR;
              end
            end
          end else begin
            char_go   = 1'b1;
            char_item = q_item;
          end
        end
      end
      S_REPLAY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_row_nxt     = ROW_BITS'(row_r);
          o_col_nxt     = COL_BITS'(dst_r);
          o_glyph_nxt   = ram_rdata;
          o_last_nxt    = 1'b0;
          ram_we        = 1'b1;
          ram_waddr     = dst_r;
          ram_wdata     = ram_rdata;
          dst_nxt       = dst_r + AW'(1);
          if (src_r == LAST_IDX) begin
            col_nxt   = CW'(dst_r) + CW'(1);
            ram_raddr = '0;
            state_nxt = S_CHAR;
          end else begin
            src_nxt   = src_r + AW'(1);
            ram_raddr = src_r + AW'(1);
          end
        end
      end
      S_CHAR: begin
        if (out_free) begin
          char_go   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // the arriving character on a row with room left
    if (char_go) begin
      out_valid_nxt = 1'b1;
      o_row_nxt     = ROW_BITS'(row_r);
      o_col_nxt     = COL_BITS'(col_r);
      o_last_nxt    = 1'b1;
      if (char_item.is_nl) begin
        o_glyph_nxt = GLYPH_EOL;
        row_nxt     = row_inc;
        col_nxt     = '0;
        sp_on_nxt   = 1'b0;
      end else begin
        o_glyph_nxt = char_item.ch;
        ram_we      = 1'b1;
        ram_waddr   = col_r[AW-1:0];
        ram_wdata   = char_item.ch;
        col_nxt     = col_r + CW'(1);
        if (char_item.is_space) begin
          sp_col_nxt = col_r[AW-1:0];
          sp_on_nxt  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      sp_col_r    <= '0;
      sp_on_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      sp_col_r    <= sp_col_nxt;
      sp_on_r     <= sp_on_nxt;
      out_valid_r <= out_valid_nxt;
      ch_r        <= ch_nxt;
      src_r       <= src_nxt;
      dst_r       <= dst_nxt;
      o_row_r     <= o_row_nxt;
      o_col_r     <= o_col_nxt;
      o_glyph_r   <= o_glyph_nxt;
      o_last_r    <= o_last_nxt;
    end
  end

endmodule

[hdl/greedy_word_wrap_line_writer.sv]
// top level of the greedy word wrap line writer
//
// usage:
//   in_*  : one message character per transfer in in_tdata; code 0 ends the
//           message and clears position and space tracking, 10 ends a row
//   out_* : one text buffer write per transfer (row, column, glyph); tlast
//           marks the final write caused by an input character
//   a plain character gives one write via the queue and the output register;
//   a sustained stream runs at one character per cycle barring wraps and stalls
//   a wrap at a space writes the terminator, then each carried-over
//   character (one read of the row ram each), then the arriving
//   character; the replay loop through the ram sets the peak cost
//   characters after the final row are dropped without any write
//   reset clears position, space tracking, queue and output register; the
//   row ram needs no clearing since replay only reads written entries
//   when the receiver stalls, the output register holds and the back end
//   waits; the two-entry queue keeps accepting until full, then in_tready
//   drops
module greedy_word_wrap_line_writer
  import gww_pkg::*;
#(
  parameter int ROW_WIDTH = 50,
  parameter int ROW_COUNT = 14
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // [7:0] character
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata,  // [3:0] row, [9:4] column, [17:10] glyph
  output logic                      out_tlast
);

  logic                 q_valid;
  gww_item_t            q_item;
  logic                 q_pop;
  logic [ROW_BITS-1:0]  o_row;
  logic [COL_BITS-1:0]  o_col;
  logic [CHAR_BITS-1:0] o_glyph;

  // front: classify and queue characters
  gww_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_char (in_tdata[CHAR_BITS-1:0]),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  // back: wrap logic, replay and output register
  gww_back #(
    .ROW_WIDTH(ROW_WIDTH),
    .ROW_COUNT(ROW_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_row   (o_row),
    .out_column(o_col),
    .out_glyph (o_glyph),
    .out_last  (out_tlast)
  );

  // pack fields from the low bit up, zero fill to whole bytes
  assign out_tdata = {
    {(OUT_TDATA_BITS - ROW_BITS - COL_BITS - CHAR_BITS){1'b0}},
    o_glyph, o_col, o_row
  };

endmodule

[hdl/gww_checker.sv]
// port level checks of the greedy word wrap line writer
module gww_checker
  import gww_pkg::*;
#(
  parameter int ROW_WIDTH = 50,
  parameter int ROW_COUNT = 14
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [OUT_TDATA_BITS-1:0] out_tdata,
  input logic                      out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

  // writes stay inside the buffer
  a_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3:0] < ROW_BITS'(ROW_COUNT))
                   && (out_tdata[9:4] <= COL_BITS'(ROW_WIDTH)))
    else $error("write outside buffer");

  // the spare column only ever gets the row terminator
  a_spare_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[9:4] == COL_BITS'(ROW_WIDTH)) |-> (out_tdata[17:10] == GLYPH_EOL))
    else $error("glyph in terminator column");

endmodule

bind greedy_word_wrap_line_writer gww_checker #(
  .ROW_WIDTH(ROW_WIDTH),
  .ROW_COUNT(ROW_COUNT)
) u_gww_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);
